FILE: design/jtl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtl_pkg
// Types, token codes and character constants shared by the JSON token lexer.
// ----------------------------------------------------------------------------
package jtl_pkg;

    typedef enum logic [3:0] {
        KIND_LBRACE    = 4'd0,
        KIND_RBRACE    = 4'd1,
        KIND_LBRACKET  = 4'd2,
        KIND_RBRACKET  = 4'd3,
        KIND_COLON     = 4'd4,
        KIND_COMMA     = 4'd5,
        KIND_NUMBER    = 4'd6,
        KIND_STR_START = 4'd7,
        KIND_STR_BYTE  = 4'd8,
        KIND_STR_END   = 4'd9,
        KIND_BOOL      = 4'd10,
        KIND_END       = 4'd11,
        KIND_ERROR     = 4'd12
    } token_kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_NUMBER  = 2'd1,
        MODE_STRING  = 2'd2,
        MODE_KEYWORD = 2'd3
    } lex_mode_t;

    localparam logic [7:0] CHAR_POINT    = 8'h2E;
    localparam logic [7:0] CHAR_QUOTE    = 8'h22;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    localparam logic [7:0] CHAR_LBRACE   = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE   = 8'h7D;
    localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
    localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
    localparam logic [7:0] CHAR_COLON    = 8'h3A;
    localparam logic [7:0] CHAR_COMMA    = 8'h2C;
    localparam logic [7:0] CHAR_T        = 8'h74;
    localparam logic [7:0] CHAR_F        = 8'h66;

    localparam logic [4:0] FRAC_MAX      = 5'd31;
    localparam logic [2:0] LEN_TRUE      = 3'd4;
    localparam logic [2:0] LEN_FALSE     = 3'd5;
    localparam int         MAX_TOKENS    = 3;

    typedef struct packed {
        token_kind_t kind;
        logic [7:0]  text_byte;
        logic [31:0] mantissa;
        logic [4:0]  frac;
        logic        ovf;
        logic        bool_val;
        logic        last;
    } token_t;

    // Tokens produced by one byte, slot 0 first
    typedef struct packed {
        logic [1:0]                  count;
        token_t [MAX_TOKENS-1:0]     slot;
    } token_group_t;

    // Letter expected at a keyword position ("true" or "false")
    function automatic logic [7:0] kw_letter(input logic is_true, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case ({is_true, pos})
            4'b1_000: ch = 8'h74;
            4'b1_001: ch = 8'h72;
            4'b1_010: ch = 8'h75;
            4'b1_011: ch = 8'h65;
            4'b0_000: ch = 8'h66;
            4'b0_001: ch = 8'h61;
            4'b0_010: ch = 8'h6C;
            4'b0_011: ch = 8'h73;
            4'b0_100: ch = 8'h65;
            default:  ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: design/jtl_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtl_core
// Lexer state and token decode: turns one text byte into zero to three tokens.
// ----------------------------------------------------------------------------
module jtl_core #(
    parameter int MANTISSA_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [7:0]           in_byte,
    input  logic                 end_of_text,
    output jtl_pkg::token_group_t group
);
    import jtl_pkg::*;

    localparam int MB = MANTISSA_BITS;

    lex_mode_t       mode_reg, mode_next, mode_mid;
    logic [MB-1:0]   acc_reg, acc_next, acc_mid;
    logic [4:0]      frac_reg, frac_next, frac_mid;
    logic            point_reg, point_next, point_mid;
    logic            ovf_reg, ovf_next, ovf_mid;
    logic [2:0]      kpos_reg, kpos_next, kpos_mid;
    logic            ktrue_reg, ktrue_next, ktrue_mid;

    logic            pre_v, idle_v;
    token_t          pre_t, idle_t;

    logic [MB+31:0]  acc_reg_ext, acc_mid_ext;
    logic [MB+3:0]   times_ten;
    logic [3:0]      digit;
    logic            is_digit;

    assign acc_reg_ext = {{32{1'b0}}, acc_reg};
    assign acc_mid_ext = {{32{1'b0}}, acc_mid};
    assign digit       = 4'(in_byte - CHAR_ZERO);
    assign is_digit    = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
    assign times_ten   = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                       + {{MB{1'b0}}, digit};

    // Byte handling in the current mode, then fresh-token handling where needed
    always_comb
    begin
        logic       redo;
        logic [2:0] kw_len;
        mode_mid  = mode_reg;
        acc_mid   = acc_reg;
        frac_mid  = frac_reg;
        point_mid = point_reg;
        ovf_mid   = ovf_reg;
        kpos_mid  = kpos_reg;
        ktrue_mid = ktrue_reg;
        pre_v     = 1'b0;
        pre_t     = '0;
        idle_v    = 1'b0;
        idle_t    = '0;
        redo      = 1'b0;
        kw_len    = ktrue_reg ? LEN_TRUE : LEN_FALSE;

        unique case (mode_reg)
            MODE_NUMBER:
            begin
                if (is_digit)
                begin
                    if (times_ten[MB+3:MB] != 4'd0)
                    begin
                        acc_mid = '1;
                        ovf_mid = 1'b1;
                    end
                    else
                    begin
                        acc_mid = times_ten[MB-1:0];
                    end
                    if (point_reg)
                    begin
                        if (frac_reg >= FRAC_MAX)
                        begin
                            frac_mid = FRAC_MAX;
                            ovf_mid  = 1'b1;
                        end
                        else
                        begin
                            frac_mid = frac_reg + 5'd1;
                        end
                    end
                end
                else if (in_byte == CHAR_POINT && !point_reg)
                begin
                    point_mid = 1'b1;
                end
                else
                begin
                    pre_v          = 1'b1;
                    pre_t.kind     = KIND_NUMBER;
                    pre_t.mantissa = acc_reg_ext[31:0];
                    pre_t.frac     = frac_reg;
                    pre_t.ovf      = ovf_reg;
                    mode_mid       = MODE_IDLE;
                    redo           = 1'b1;
                end
            end
            MODE_STRING:
            begin
                pre_v = 1'b1;
                if (in_byte == CHAR_QUOTE)
                begin
                    pre_t.kind = KIND_STR_END;
                    mode_mid   = MODE_IDLE;
                end
                else
                begin
                    pre_t.kind      = KIND_STR_BYTE;
                    pre_t.text_byte = in_byte;
                end
            end
            MODE_KEYWORD:
            begin
                pre_v = 1'b0;
                if (kpos_reg < kw_len && in_byte == kw_letter(ktrue_reg, kpos_reg))
                begin
                    kpos_mid = kpos_reg + 3'd1;
                    if (kpos_mid == kw_len)
                    begin
                        pre_v          = 1'b1;
                        pre_t.kind     = KIND_BOOL;
                        pre_t.bool_val = ktrue_reg;
                        mode_mid       = MODE_IDLE;
                        kpos_mid       = 3'd0;
                    end
                end
                else
                begin
                    pre_v      = 1'b1;
                    pre_t.kind = KIND_ERROR;
                    mode_mid   = MODE_IDLE;
                    kpos_mid   = 3'd0;
                    redo       = 1'b1;
                end
            end
            default:
            begin
                redo = 1'b1;
            end
        endcase

        if (redo)
        begin
            unique case (in_byte)
                CHAR_LBRACE:   begin idle_v = 1'b1; idle_t.kind = KIND_LBRACE;   end
                CHAR_RBRACE:   begin idle_v = 1'b1; idle_t.kind = KIND_RBRACE;   end
                CHAR_LBRACKET: begin idle_v = 1'b1; idle_t.kind = KIND_LBRACKET; end
                CHAR_RBRACKET: begin idle_v = 1'b1; idle_t.kind = KIND_RBRACKET; end
                CHAR_COLON:    begin idle_v = 1'b1; idle_t.kind = KIND_COLON;    end
                CHAR_COMMA:    begin idle_v = 1'b1; idle_t.kind = KIND_COMMA;    end
                CHAR_QUOTE:
                begin
                    idle_v      = 1'b1;
                    idle_t.kind = KIND_STR_START;
                    mode_mid    = MODE_STRING;
                end
                CHAR_T, CHAR_F:
                begin
                    mode_mid  = MODE_KEYWORD;
                    kpos_mid  = 3'd1;
                    ktrue_mid = (in_byte == CHAR_T);
                end
                default:
                begin
                    if (is_digit)
                    begin
                        mode_mid  = MODE_NUMBER;
                        acc_mid   = {{(MB-4){1'b0}}, digit};
                        frac_mid  = 5'd0;
                        point_mid = 1'b0;
                        ovf_mid   = 1'b0;
                    end
                end
            endcase
        end
    end

    // End-of-text handling, token packing and next state
    always_comb
    begin
        logic   end1_v, end2_v;
        token_t end1_t, end2_t;
        logic [1:0] n;
        end1_v = 1'b0;
        end2_v = 1'b0;
        end1_t = '0;
        end2_t = '0;
        n      = 2'd0;
        group  = '0;

        mode_next  = mode_mid;
        acc_next   = acc_mid;
        frac_next  = frac_mid;
        point_next = point_mid;
        ovf_next   = ovf_mid;
        kpos_next  = kpos_mid;
        ktrue_next = ktrue_mid;

        if (end_of_text)
        begin
            end1_v = 1'b1;
            unique case (mode_mid)
                MODE_NUMBER:
                begin
                    end1_t.kind     = KIND_NUMBER;
                    end1_t.mantissa = acc_mid_ext[31:0];
                    end1_t.frac     = frac_mid;
                    end1_t.ovf      = ovf_mid;
                    end2_v          = 1'b1;
                    end2_t.kind     = KIND_END;
                end
                MODE_STRING, MODE_KEYWORD:
                begin
                    end1_t.kind = KIND_ERROR;
                end
                default:
                begin
                    end1_t.kind = KIND_END;
                end
            endcase
            mode_next  = MODE_IDLE;
            acc_next   = '0;
            frac_next  = 5'd0;
            point_next = 1'b0;
            ovf_next   = 1'b0;
            kpos_next  = 3'd0;
            ktrue_next = 1'b0;
        end

        if (pre_v)
        begin
            group.slot[n] = pre_t;
            n = n + 2'd1;
        end
        if (idle_v)
        begin
            group.slot[n] = idle_t;
            n = n + 2'd1;
        end
        if (end1_v && n != 2'd3)
        begin
            group.slot[n] = end1_t;
            n = n + 2'd1;
        end
        if (end2_v && n != 2'd3)
        begin
            group.slot[n] = end2_t;
            n = n + 2'd1;
        end
        if (n != 2'd0)
        begin
            group.slot[n - 2'd1].last = 1'b1;
        end
        group.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            acc_reg   <= '0;
            frac_reg  <= 5'd0;
            point_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            kpos_reg  <= 3'd0;
            ktrue_reg <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            frac_reg  <= frac_next;
            point_reg <= point_next;
            ovf_reg   <= ovf_next;
            kpos_reg  <= kpos_next;
            ktrue_reg <= ktrue_next;
        end
    end

    a_kpos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != MODE_KEYWORD |-> kpos_reg == 3'd0)
        else $error("keyword position left set outside a keyword");

    a_kpos_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_KEYWORD |-> (kpos_reg != 3'd0 && kpos_reg < (ktrue_reg ? LEN_TRUE : LEN_FALSE)))
        else $error("keyword position out of range");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && end_of_text |=> mode_reg == MODE_IDLE && acc_reg == '0 && !ovf_reg)
        else $error("state not cleared after end of text");

endmodule

FILE: design/jtl_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtl_out_queue
// Three-slot result register: loads the tokens of one byte, drains one per
// transfer from slot 0.
// ----------------------------------------------------------------------------
module jtl_out_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  jtl_pkg::token_group_t group,
    output logic                  can_load,
    output logic                  out_valid,
    input  logic                  out_ready,
    output jtl_pkg::token_t       head
);
    import jtl_pkg::*;

    logic [1:0]              count_reg, count_next;
    token_t [MAX_TOKENS-1:0] slot_reg, slot_next;
    logic                    pop;

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign can_load  = (count_reg == 2'd0) || (count_reg == 2'd1 && out_ready);
    assign head      = slot_reg[0];

    always_comb
    begin
        count_next = count_reg;
        slot_next  = slot_reg;
        if (load)
        begin
            count_next = group.count;
            slot_next  = group.slot;
        end
        else if (pop)
        begin
            // advance remaining tokens toward slot 0
            count_next  = count_reg - 2'd1;
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    a_load_ok: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> can_load)
        else $error("tokens loaded over undelivered tokens");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !load |=> count_reg == $past(count_reg) - 2'd1)
        else $error("token count did not drop after transfer");

    a_last_tail: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd1 |-> slot_reg[0].last)
        else $error("final remaining token not marked last");

endmodule

FILE: design/json_token_lexer_top.sv
`timescale 1ns / 1ps
// Path: a byte is taken into the input register, then its tokens into the result register.
// Throughput: one byte per cycle while each byte yields at most one token and
// out_ready stays high; a byte yielding more tokens holds the input until
// they drain, one per transfer, from the three-slot result register.
// Reset: rst_n asynchronously clears the lexer state and empties both stages.
// ----------------------------------------------------------------------------
// json_token_lexer_top
// Byte-serial JSON tokenizer: input register, lexer core, result register.
// ----------------------------------------------------------------------------
module json_token_lexer_top #(
    parameter int MANTISSA_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_kind,
    output logic [7:0]  text_byte,
    output logic [31:0] number_mantissa,
    output logic [4:0]  fraction_digits,
    output logic        number_overflow,
    output logic        bool_value,
    output logic        last_of_run
);
    import jtl_pkg::*;

    logic         s1_valid_reg;
    logic [7:0]   s1_byte_reg;
    logic         s1_eot_reg;
    logic         advance;
    logic         can_load;
    token_group_t group;
    token_t       head;

    assign advance  = s1_valid_reg && can_load;
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // hold the byte until the result register can take its tokens
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= in_byte;
            s1_eot_reg  <= end_of_text;
        end
    end

    jtl_core #(
        .MANTISSA_BITS (MANTISSA_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .in_byte     (s1_byte_reg),
        .end_of_text (s1_eot_reg),
        .group       (group)
    );

    jtl_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .group     (group),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign token_kind      = head.kind;
    assign text_byte       = head.text_byte;
    assign number_mantissa = head.mantissa;
    assign fraction_digits = head.frac;
    assign number_overflow = head.ovf;
    assign bool_value      = head.bool_val;
    assign last_of_run     = head.last;

endmodule

FILE: tb/tb_json_token_lexer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_token_lexer_top
// Drives byte streams into the JSON token lexer and checks every token. A
// short table covers punctuation, strings, keywords, numbers and end of text.
// Random JSON-like fragments follow, with noise, under several sender and
// receiver throttling patterns. Tokens are predicted per accepted byte and
// compared in order.
// ----------------------------------------------------------------------------
module tb_json_token_lexer_top;
    import jtl_pkg::*;

    localparam logic [63:0] MANT_LIMIT      = 64'h0000_0000_FFFF_FFFF;
    localparam int          ITEMS_PER_PHASE = 125;
    localparam int          WATCHDOG_LIMIT  = 3000;
    localparam int          DRAIN_CYCLES    = 20;

    typedef struct packed {
        logic [7:0]  ch;
        logic        eot;
        logic        pin;
        token_kind_t kind;
        logic [7:0]  text;
    } lex_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        end_of_text;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  token_kind;
    logic [7:0]  text_byte;
    logic [31:0] number_mantissa;
    logic [4:0]  fraction_digits;
    logic        number_overflow;
    logic        bool_value;
    logic        last_of_run;

    // Lexer state mirrored by the predictor
    lex_mode_t   lx_mode;
    logic [63:0] lx_acc;
    logic [4:0]  lx_frac;
    logic        lx_point;
    logic        lx_ovf;
    logic [2:0]  lx_kw_pos;
    logic        lx_kw_true;

    token_t      byte_tokens[$];
    token_t      expected_tokens[$];

    // Typed-in token for the current table row, held with the payload
    logic        drv_pin;
    token_t      drv_tok;

    int          idle_pct;
    int          stall_pct;
    int          text_items;
    int          fail_count;
    int          quiet_cycles;
    logic [7:0]  punct_set [6];
    lex_row_t    dir_rows [25];

    json_token_lexer_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_byte         (in_byte),
        .end_of_text     (end_of_text),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .token_kind      (token_kind),
        .text_byte       (text_byte),
        .number_mantissa (number_mantissa),
        .fraction_digits (fraction_digits),
        .number_overflow (number_overflow),
        .bool_value      (bool_value),
        .last_of_run     (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void add_token(token_kind_t k, logic [7:0] t, logic [31:0] m,
                                      logic [4:0] f, logic o, logic bv);
        token_t tk;
        tk.kind      = k;
        tk.text_byte = t;
        tk.mantissa  = m;
        tk.frac      = f;
        tk.ovf       = o;
        tk.bool_val  = bv;
        tk.last      = 1'b0;
        byte_tokens.push_back(tk);
    endfunction

    function automatic void clear_lexer();
        lx_mode    = MODE_IDLE;
        lx_acc     = '0;
        lx_frac    = '0;
        lx_point   = 1'b0;
        lx_ovf     = 1'b0;
        lx_kw_pos  = '0;
        lx_kw_true = 1'b0;
    endfunction

    // Handle a byte with no token open
    function automatic void start_token(logic [7:0] c);
        case (c)
            CHAR_LBRACE:   add_token(KIND_LBRACE, 8'h00, '0, '0, 1'b0, 1'b0);
            CHAR_RBRACE:   add_token(KIND_RBRACE, 8'h00, '0, '0, 1'b0, 1'b0);
            CHAR_LBRACKET: add_token(KIND_LBRACKET, 8'h00, '0, '0, 1'b0, 1'b0);
            CHAR_RBRACKET: add_token(KIND_RBRACKET, 8'h00, '0, '0, 1'b0, 1'b0);
            CHAR_COLON:    add_token(KIND_COLON, 8'h00, '0, '0, 1'b0, 1'b0);
            CHAR_COMMA:    add_token(KIND_COMMA, 8'h00, '0, '0, 1'b0, 1'b0);
            CHAR_QUOTE:
            begin
                lx_mode = MODE_STRING;
                add_token(KIND_STR_START, 8'h00, '0, '0, 1'b0, 1'b0);
            end
            CHAR_T, CHAR_F:
            begin
                lx_mode    = MODE_KEYWORD;
                lx_kw_pos  = 3'd1;
                lx_kw_true = (c == CHAR_T);
            end
            default:
            begin
                if (c >= CHAR_ZERO && c <= CHAR_NINE)
                begin
                    lx_mode  = MODE_NUMBER;
                    lx_acc   = 64'(c - CHAR_ZERO);
                    lx_frac  = '0;
                    lx_point = 1'b0;
                    lx_ovf   = 1'b0;
                end
            end
        endcase
    endfunction

    // Work out the tokens one accepted byte causes and queue them
    function automatic void tokenize_byte(logic [7:0] c, logic eot);
        logic [63:0] digit;
        string       word;
        byte_tokens.delete();
        case (lx_mode)
            MODE_NUMBER:
            begin
                if (c >= CHAR_ZERO && c <= CHAR_NINE)
                begin
                    digit = 64'(c - CHAR_ZERO);
                    if (lx_acc > (MANT_LIMIT - digit) / 64'd10)
                    begin
                        lx_acc = MANT_LIMIT;
                        lx_ovf = 1'b1;
                    end
                    else
                        lx_acc = lx_acc * 64'd10 + digit;
                    if (lx_point)
                    begin
                        if (lx_frac >= FRAC_MAX)
                        begin
                            lx_frac = FRAC_MAX;
                            lx_ovf  = 1'b1;
                        end
                        else
                            lx_frac = lx_frac + 5'd1;
                    end
                end
                else if (c == CHAR_POINT && !lx_point)
                    lx_point = 1'b1;
                else
                begin
                    add_token(KIND_NUMBER, 8'h00, lx_acc[31:0], lx_frac, lx_ovf, 1'b0);
                    lx_mode = MODE_IDLE;
                    start_token(c);
                end
            end
            MODE_STRING:
            begin
                if (c == CHAR_QUOTE)
                begin
                    add_token(KIND_STR_END, 8'h00, '0, '0, 1'b0, 1'b0);
                    lx_mode = MODE_IDLE;
                end
                else
                    add_token(KIND_STR_BYTE, c, '0, '0, 1'b0, 1'b0);
            end
            MODE_KEYWORD:
            begin
                if (lx_kw_true)
                    word = "true";
                else
                    word = "false";
                if (lx_kw_pos < word.len() && c == word[lx_kw_pos])
                begin
                    lx_kw_pos = lx_kw_pos + 3'd1;
                    if (lx_kw_pos == word.len())
                    begin
                        add_token(KIND_BOOL, 8'h00, '0, '0, 1'b0, lx_kw_true);
                        lx_mode   = MODE_IDLE;
                        lx_kw_pos = '0;
                    end
                end
                else
                begin
                    add_token(KIND_ERROR, 8'h00, '0, '0, 1'b0, 1'b0);
                    lx_mode   = MODE_IDLE;
                    lx_kw_pos = '0;
                    start_token(c);
                end
            end
            default: start_token(c);
        endcase

        if (eot)
        begin
            if (lx_mode == MODE_NUMBER)
            begin
                add_token(KIND_NUMBER, 8'h00, lx_acc[31:0], lx_frac, lx_ovf, 1'b0);
                add_token(KIND_END, 8'h00, '0, '0, 1'b0, 1'b0);
            end
            else if (lx_mode == MODE_STRING || lx_mode == MODE_KEYWORD)
                add_token(KIND_ERROR, 8'h00, '0, '0, 1'b0, 1'b0);
            else
                add_token(KIND_END, 8'h00, '0, '0, 1'b0, 1'b0);
            clear_lexer();
        end

        if (byte_tokens.size() > 0)
            byte_tokens[byte_tokens.size() - 1].last = 1'b1;
    endfunction

    // Present one byte, then hold it until the transfer
    task automatic drive_byte(input logic [7:0] b, input logic eot, input logic pin,
                              input token_t pt);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        in_byte     <= b;
        end_of_text <= eot;
        drv_pin     <= pin;
        drv_tok     <= pt;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic put_byte(input logic [7:0] b, input bit counted = 1'b1);
        drive_byte(b, $urandom_range(99) < 3, 1'b0, '0);
        if (counted)
            text_items++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic put_digits(input int count);
        repeat (count) put_byte(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin : monitor
        token_t got;
        token_t want;
        logic   moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                moved              = 1'b1;
                got.kind           = token_kind_t'(token_kind);
                got.text_byte      = text_byte;
                got.mantissa       = number_mantissa;
                got.frac           = fraction_digits;
                got.ovf            = number_overflow;
                got.bool_val       = bool_value;
                got.last           = last_of_run;
                if (expected_tokens.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected token: kind %0d text %02h mant %0d",
                                 got.kind, got.text_byte, got.mantissa);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"token mismatch: expected kind %0d text %02h mant %0d ",
                                      "frac %0d ovf %b bool %b last %b, got kind %0d text %02h ",
                                      "mant %0d frac %0d ovf %b bool %b last %b"},
                                     want.kind, want.text_byte, want.mantissa, want.frac,
                                     want.ovf, want.bool_val, want.last,
                                     got.kind, got.text_byte, got.mantissa, got.frac,
                                     got.ovf, got.bool_val, got.last);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                moved = 1'b1;
                tokenize_byte(in_byte, end_of_text);
                // Table rows with a typed-in token replace the prediction
                if (drv_pin)
                    expected_tokens.push_back(drv_tok);
                else
                    foreach (byte_tokens[i])
                        expected_tokens.push_back(byte_tokens[i]);
            end
            if (moved)
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles == WATCHDOG_LIMIT)
                begin
                    $display("tb_json_token_lexer_top: FAIL");
                    $finish;
                end
            end
        end
    end

    initial
    begin : stimulus
        int         k;
        int         n;
        string      word;
        logic [7:0] b;
        token_t     pt;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_byte      = 8'h00;
        end_of_text  = 1'b0;
        drv_pin      = 1'b0;
        drv_tok      = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        text_items   = 0;
        fail_count   = 0;
        quiet_cycles = 0;
        clear_lexer();
        punct_set = '{CHAR_LBRACE, CHAR_RBRACE, CHAR_LBRACKET, CHAR_RBRACKET,
                      CHAR_COLON, CHAR_COMMA};

        // ch, end_of_text, typed-in, kind, text byte
        dir_rows = '{
            '{CHAR_LBRACE,   1'b0, 1'b1, KIND_LBRACE,    8'h00},
            '{CHAR_RBRACE,   1'b0, 1'b1, KIND_RBRACE,    8'h00},
            '{CHAR_LBRACKET, 1'b0, 1'b1, KIND_LBRACKET,  8'h00},
            '{CHAR_RBRACKET, 1'b0, 1'b1, KIND_RBRACKET,  8'h00},
            '{CHAR_COLON,    1'b0, 1'b1, KIND_COLON,     8'h00},
            '{CHAR_COMMA,    1'b0, 1'b1, KIND_COMMA,     8'h00},
            '{CHAR_QUOTE,    1'b0, 1'b1, KIND_STR_START, 8'h00},
            '{8'h00,         1'b0, 1'b1, KIND_STR_BYTE,  8'h00},
            '{8'hFF,         1'b0, 1'b1, KIND_STR_BYTE,  8'hFF},
            '{CHAR_QUOTE,    1'b0, 1'b1, KIND_STR_END,   8'h00},
            '{CHAR_T,        1'b0, 1'b0, KIND_ERROR,     8'h00},
            '{"r",           1'b0, 1'b0, KIND_ERROR,     8'h00},
            '{"x",           1'b0, 1'b1, KIND_ERROR,     8'h00},
            '{CHAR_F,        1'b0, 1'b0, KIND_ERROR,     8'h00},
            '{"a",           1'b0, 1'b0, KIND_ERROR,     8'h00},
            '{"l",           1'b0, 1'b0, KIND_ERROR,     8'h00},
            '{"s",           1'b0, 1'b0, KIND_ERROR,     8'h00},
            '{"e",           1'b0, 1'b0, KIND_ERROR,     8'h00},
            '{"1",           1'b0, 1'b0, KIND_ERROR,     8'h00},
            '{CHAR_POINT,    1'b0, 1'b0, KIND_ERROR,     8'h00},
            '{CHAR_POINT,    1'b0, 1'b0, KIND_ERROR,     8'h00},
            '{"9",           1'b1, 1'b0, KIND_ERROR,     8'h00},
            '{CHAR_QUOTE,    1'b1, 1'b0, KIND_ERROR,     8'h00},
            '{8'h00,         1'b1, 1'b1, KIND_END,       8'h00},
            '{CHAR_T,        1'b1, 1'b1, KIND_ERROR,     8'h00}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            pt           = '0;
            pt.kind      = dir_rows[i].kind;
            pt.text_byte = dir_rows[i].text;
            pt.last      = 1'b1;
            drive_byte(dir_rows[i].ch, dir_rows[i].eot, dir_rows[i].pin, pt);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 76; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 76; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            text_items = 0;
            while (text_items < ITEMS_PER_PHASE)
            begin
                k = $urandom_range(99);
                if (k < 25)
                    put_byte(punct_set[$urandom_range(5)]);
                else if (k < 50)
                begin
                    n = $urandom_range(99);
                    if (n < 60)
                    begin
                        put_digits($urandom_range(1, 6));
                        if ($urandom_range(2) == 0)
                        begin
                            put_byte(CHAR_POINT);
                            put_digits($urandom_range(0, 4));
                        end
                    end
                    else if (n < 78)
                        put_digits($urandom_range(9, 14));
                    else if (n < 88)
                    begin
                        // Land on both sides of the mantissa limit
                        case ($urandom_range(2))
                            0: put_text("4294967295");
                            1: put_text("4294967296");
                            default: put_text("429496729.5");
                        endcase
                    end
                    else
                    begin
                        put_text("0.");
                        put_digits($urandom_range(29, 34));
                    end
                    // Second or trailing point
                    if ($urandom_range(9) == 0)
                        put_byte(CHAR_POINT);
                end
                else if (k < 70)
                begin
                    put_byte(CHAR_QUOTE);
                    repeat ($urandom_range(0, 6))
                    begin
                        b = 8'($urandom);
                        if (b == CHAR_QUOTE)
                            b = 8'h00;
                        put_byte(b);
                    end
                    if ($urandom_range(9) != 0)
                        put_byte(CHAR_QUOTE);
                end
                else if (k < 90)
                begin
                    if ($urandom_range(1) == 1)
                        word = "true";
                    else
                        word = "false";
                    // Break the keyword at a random letter now and then
                    n = ($urandom_range(3) == 0) ? $urandom_range(1, word.len() - 1)
                                                 : word.len();
                    for (int i = 0; i < word.len() && i <= n; i++)
                    begin
                        if (i == n)
                            put_byte(8'($urandom));
                        else
                            put_byte(word[i]);
                    end
                end
                else
                    put_byte(8'($urandom), 1'b0);

                if ($urandom_range(9) < 3)
                    put_byte(($urandom_range(1) == 1) ? 8'h20 : 8'h0A, 1'b0);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("tb_json_token_lexer_top: PASS");
        else
            $display("tb_json_token_lexer_top: FAIL");
        $finish;
    end

endmodule
